>>> src/scf_pkg.sv
// Shared constants and types for the SLIP capture framer.
package scf_pkg;

    localparam logic [1:0] MODE_HDR = 2'd0;
    localparam logic [1:0] MODE_PAY = 2'd1;
    localparam logic [1:0] MODE_END = 2'd2;

    localparam logic [7:0] SLIP_END     = 8'hc0;
    localparam logic [7:0] SLIP_ESC     = 8'hdb;
    localparam logic [7:0] SLIP_ESC_END = 8'hdc;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hdd;

    localparam int REC_BYTES = 16;
    localparam int IDX_W     = $clog2(REC_BYTES);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic                     raw;
        logic [IDX_W-1:0]         last_idx;
        t_byte [REC_BYTES-1:0]    data;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

>>> src/scf_in_if.sv
// Input request channel of the SLIP capture framer.
interface scf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  payload_byte;
    logic [31:0] packet_length;
    logic [7:0]  link_quality;
    logic [63:0] capture_time_us;

    modport source (
        output valid, mode, payload_byte, packet_length, link_quality, capture_time_us,
        input  ready
    );
    modport sink (
        input  valid, mode, payload_byte, packet_length, link_quality, capture_time_us,
        output ready
    );
endinterface

>>> src/scf_out_if.sv
// Output byte channel of the SLIP capture framer.
interface scf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (
        output valid, out_byte, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_run,
        output ready
    );
endinterface

>>> src/slip_capture_framer_unit.sv
// Top level of the SLIP capture framer.
//
// Usage:
//   i_in  : request channel. mode 0 carries a header (length, quality,
//           timestamp), mode 1 one payload byte, mode 2 a frame end marker.
//           Mode 3 requests are accepted and give no output.
//   o_out : one stuffed serial byte per transfer; last_of_run marks the
//           final byte that belongs to a request.
// Path: an accepted request is first written into the record queue; its
//   first byte is then loaded into the output register when the output is free.
// Throughput: the back end emits one byte per cycle unless o_out stalls;
//   a request yields 1 byte for an end marker, 1 or 2 for a payload
//   byte and 16 to 32 for a header. The two-entry record queue lets
//   the input keep taking requests while the back end works.
// Reset: synchronous, active low; empties the queue and the output
//   register. Nothing else is held across requests.
// Stall: when o_out.ready is low the output register holds its byte, the
//   back end stops, and i_in.ready falls once the queue is full.
module slip_capture_framer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scf_in_if.sink     i_in,
    scf_out_if.source  o_out
);
    import scf_pkg::*;

    t_push w_push;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    scf_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push)
    );

    scf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    scf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> src/scf_front.sv
// Front end: accept requests and build byte records for the queue.
module scf_front (
    scf_in_if.sink          i_in,
    input  logic            i_full,
    output scf_pkg::t_push  o_push
);
    import scf_pkg::*;

    t_cmd w_cmd;
    logic w_known;

    always_comb begin
        w_cmd   = '0;
        w_known = 1'b1;
        case (i_in.mode)
            MODE_HDR: begin
                w_cmd.raw      = 1'b0;
                w_cmd.last_idx = IDX_W'(REC_BYTES - 1);
                w_cmd.data     = {i_in.packet_length, i_in.link_quality, 24'h0,
                                  i_in.capture_time_us};
            end
            MODE_PAY: begin
                w_cmd.raw                 = 1'b0;
                w_cmd.last_idx            = '0;
                w_cmd.data[REC_BYTES-1]   = i_in.payload_byte;
            end
            MODE_END: begin
                w_cmd.raw                 = 1'b1;
                w_cmd.last_idx            = '0;
                w_cmd.data[REC_BYTES-1]   = SLIP_END;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    // drop unused mode codes at the door
    assign i_in.ready  = !i_full;
    assign o_push.push = i_in.valid && !i_full && w_known;
    assign o_push.cmd  = w_cmd;

endmodule

>>> src/scf_queue.sv
// Short queue of byte records between front and back end.
module scf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scf_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_full,
    output scf_pkg::t_head  o_head
);
    import scf_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_PTR_W-1:0] n_wr;
    logic [Q_PTR_W-1:0] n_rd;
    logic [Q_CNT_W-1:0] n_cnt;
    logic               w_pop;

    assign o_full       = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push.push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

endmodule

>>> src/scf_back.sv
// Back end: walk record bytes, stuff them and drive the output register.
module scf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scf_pkg::t_head  i_head,
    output logic            o_pop,
    scf_out_if.source       o_out
);
    import scf_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_esc;
    logic             r_ov;
    t_byte            r_byte;
    logic             r_last;
    logic [IDX_W-1:0] n_idx;
    logic             n_esc;
    t_byte            w_cur;
    t_byte            w_byte;
    logic             w_need_esc;
    logic             w_done;
    logic             w_last;
    logic             w_step;

    assign w_cur      = i_head.cmd.data[~r_idx];
    assign w_need_esc = !i_head.cmd.raw && ((w_cur == SLIP_END) || (w_cur == SLIP_ESC));
    assign w_done     = r_esc || !w_need_esc;
    assign w_last     = w_done && (r_idx == i_head.cmd.last_idx);
    assign w_step     = i_head.valid && (!r_ov || o_out.ready);
    assign o_pop      = w_step && w_last;

    always_comb begin
        if (r_esc) begin
            w_byte = (w_cur == SLIP_END) ? SLIP_ESC_END : SLIP_ESC_ESC;
        end else if (w_need_esc) begin
            w_byte = SLIP_ESC;
        end else begin
            w_byte = w_cur;
        end
    end

    always_comb begin
        n_idx = r_idx;
        n_esc = r_esc;
        if (w_step) begin
            if (w_done) begin
                n_esc = 1'b0;
                n_idx = w_last ? '0 : r_idx + 1'b1;
            end else begin
                n_esc = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_esc <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_esc <= n_esc;
            if (w_step) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_byte <= w_byte;
            r_last <= w_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_of_run = r_last;

endmodule

>>> src/scf_checker.sv
// Port-level checks for the SLIP capture framer, bound to the top level.
module scf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    import scf_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output byte changed while stalled");

    a_esc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_byte == SLIP_ESC) |-> !i_out_last)
        else $error("escape byte ended a request");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_byte == SLIP_END) |-> i_out_last)
        else $error("bare end byte inside stuffed data");

endmodule

bind slip_capture_framer_unit scf_checker u_scf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run)
);
